// ===== rtl/png_scanline_unfilter_assert.svh =====
// Assertion macros used by the checker file of the scanline unfilter.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef PNG_SCANLINE_UNFILTER_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_ASSERT_SVH

// Implication checked in the same cycle, suspended during reset.
`define PSU_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("port assertion failed");

// Implication checked in the next cycle, suspended during reset.
`define PSU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("port assertion failed");

// Implication checked in the next cycle, also across reset.
`define PSU_ASSERT_NEXT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("port assertion failed");

`endif

// ===== rtl/psu_pkg.sv =====
// Package for the PNG scanline unfilter: constants, codes and the Paeth predictor.
// Depends on nothing.
package psu_pkg;

  // Default sizes of the line store and the pixel registers.
  localparam int DEF_MAX_ROW_BYTES = 8192;
  localparam int DEF_MAX_CHANNELS  = 4;

  // Byte position counter: a row holds at most 16383 pixels of at most 7 bytes.
  localparam int POS_W = 17;

  // Register field widths.
  localparam int WIDTH_W  = 14;
  localparam int CHAN_W   = 3;
  localparam int HEIGHT_W = 16;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_ROW_WIDTH     = 2'd0,
    REG_CHANNEL_COUNT = 2'd1,
    REG_IMAGE_HEIGHT  = 2'd2
  } reg_idx_t;

  // Filter types of PNG filter method 0.
  typedef enum logic [2:0] {
    FILT_NONE    = 3'd0,
    FILT_SUB     = 3'd1,
    FILT_UP      = 3'd2,
    FILT_AVERAGE = 3'd3,
    FILT_PAETH   = 3'd4
  } filt_t;

  localparam logic [7:0] FILT_LAST = 8'd4;

  // Paeth predictor: the neighbor closest to a + b - c, ties go to a, then b.
  function automatic logic [7:0] paeth_pred(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    logic signed [9:0] da;
    logic signed [9:0] db;
    logic signed [9:0] dc;
    logic [9:0] pa;
    logic [9:0] pb;
    logic [9:0] pc;
    da = $signed({2'b00, b}) - $signed({2'b00, c});
    db = $signed({2'b00, a}) - $signed({2'b00, c});
    dc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
    pa = (da < 0) ? 10'(-da) : 10'(da);
    pb = (db < 0) ? 10'(-db) : 10'(db);
    pc = (dc < 0) ? 10'(-dc) : 10'(dc);
    if (pa <= pb && pa <= pc) begin
      return a;
    end else if (pb <= pc) begin
      return b;
    end
    return c;
  endfunction

endpackage

// ===== rtl/png_scanline_unfilter.sv =====
// PNG scanline unfilter, 8-bit samples: position counters, prior-row line store,
// neighbor registers and the reconstruction datapath. Depends on psu_pkg.
//
// Throughput: one byte per clock cycle, filter bytes included, while out_ready is not held low.
// On acceptance a sample loads the input register and reads the line store; it moves on
// to the result register when that register is free or being emptied.
// Reset is synchronous and active low; it clears counters and neighbor registers and sets
// the configuration to defaults. The line store is not cleared and needs no clearing pass.
module png_scanline_unfilter
  import psu_pkg::*;
#(
  parameter int MAX_ROW_BYTES = DEF_MAX_ROW_BYTES,
  parameter int MAX_CHANNELS  = DEF_MAX_CHANNELS
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_stream_byte,
  // Result stream
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_pixel_byte,
  output logic        out_row_end,
  output logic        out_image_end,
  output logic        out_bad_filter,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW   = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  // Configuration registers.
  logic [WIDTH_W-1:0]  row_width_r;
  logic [CHAN_W-1:0]   channel_count_r;
  logic [HEIGHT_W-1:0] image_height_r;

  // Row and image position state.
  logic                awaiting_r;
  logic [7:0]          filt_r;
  logic [POS_W-1:0]    pos_r;
  logic [HEIGHT_W-1:0] row_idx_r;
  logic [CH_W-1:0]     mod_r [MAX_CHANNELS];

  // Input register stage.
  logic                s1_valid_r;
  logic [7:0]          s1_x_r;
  logic [AW-1:0]       s1_addr_r;
  logic                s1_in_store_r;
  logic [CH_W-1:0]     s1_ch_r;
  logic                s1_first_pixel_r;
  logic                s1_first_row_r;
  logic                s1_bad_r;
  logic [2:0]          s1_filt_r;
  logic                s1_row_end_r;
  logic                s1_image_end_r;

  // Line store and its read path.
  logic [7:0]          line_mem [MAX_ROW_BYTES];
  logic [7:0]          rd_raw_r;
  logic                byp_r;
  logic [7:0]          byp_data_r;

  // Neighbor registers.
  logic [7:0]          left_r [MAX_CHANNELS];
  logic [7:0]          upleft_r [MAX_CHANNELS];

  // Result register.
  logic                out_valid_r;
  logic [7:0]          out_pixel_r;
  logic                out_row_end_r;
  logic                out_image_end_r;
  logic                out_bad_r;

  logic                in_fire;
  logic                data_fire;
  logic                s1_fire;
  logic                cfg_wr;

  // ---------------------------------------------------------------------------
  // Configuration port: always ready, read data decoded from the word index.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r     <= WIDTH_W'(1);
      channel_count_r <= CHAN_W'(3);
      image_height_r  <= HEIGHT_W'(1);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ROW_WIDTH:     row_width_r     <= pwdata[WIDTH_W-1:0];
        REG_CHANNEL_COUNT: channel_count_r <= pwdata[CHAN_W-1:0];
        REG_IMAGE_HEIGHT:  image_height_r  <= pwdata[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ROW_WIDTH:     prdata = 32'(row_width_r);
      REG_CHANNEL_COUNT: prdata = 32'(channel_count_r);
      REG_IMAGE_HEIGHT:  prdata = 32'(image_height_r);
      default:           prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Effective geometry: zero acts as one, channels clamp to MAX_CHANNELS.
  logic [CHAN_W-1:0]         chans;
  logic [WIDTH_W-1:0]        width_eff;
  logic [HEIGHT_W-1:0]       height_eff;
  logic [WIDTH_W+CHAN_W-1:0] row_bytes;

  always_comb begin
    if (channel_count_r == '0) begin
      chans = CHAN_W'(1);
    end else if (32'(channel_count_r) > MAX_CHANNELS) begin
      chans = CHAN_W'(MAX_CHANNELS);
    end else begin
      chans = channel_count_r;
    end
    width_eff  = (row_width_r == '0) ? WIDTH_W'(1) : row_width_r;
    height_eff = (image_height_r == '0) ? HEIGHT_W'(1) : image_height_r;
    row_bytes  = width_eff * chans;
  end

  // ---------------------------------------------------------------------------
  // Decode of the byte being accepted. Each modulus keeps its own channel
  // counter, so a channel count changed mid-row still gives position mod count.
  logic [CH_W-1:0]     acc_ch;
  logic                acc_first_pixel;
  logic                acc_in_store;
  logic                acc_bad;
  logic                acc_row_end;
  logic                acc_image_end;
  logic [POS_W:0]      pos_inc;
  logic [HEIGHT_W:0]   row_inc;

  always_comb begin
    acc_ch = '0;
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      if (chans == CHAN_W'(i + 1)) begin
        acc_ch = mod_r[i];
      end
    end
    acc_first_pixel = pos_r < POS_W'(chans);
    acc_in_store    = 32'(pos_r) < MAX_ROW_BYTES;
    acc_bad         = !acc_in_store || (filt_r > FILT_LAST);
    pos_inc         = {1'b0, pos_r} + (POS_W+1)'(1);
    row_inc         = {1'b0, row_idx_r} + (HEIGHT_W+1)'(1);
    acc_row_end     = pos_inc >= (POS_W+1)'(row_bytes);
    acc_image_end   = acc_row_end && (row_inc >= (HEIGHT_W+1)'(height_eff));
  end

  // ---------------------------------------------------------------------------
  // Handshakes: the input register moves on whenever the result register frees.
  assign s1_fire   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_fire;
  assign in_fire   = in_valid && in_ready;
  assign data_fire = in_fire && !awaiting_r;

  // Row, channel and image counters advance as bytes are accepted.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r <= 1'b1;
      filt_r     <= '0;
      pos_r      <= '0;
      row_idx_r  <= '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        mod_r[i] <= '0;
      end
    end else if (in_fire) begin
      if (awaiting_r) begin
        filt_r     <= in_stream_byte;
        awaiting_r <= 1'b0;
        pos_r      <= '0;
        for (int i = 0; i < MAX_CHANNELS; i++) begin
          mod_r[i] <= '0;
        end
      end else if (acc_row_end) begin
        awaiting_r <= 1'b1;
        pos_r      <= '0;
        row_idx_r  <= acc_image_end ? '0 : row_inc[HEIGHT_W-1:0];
        for (int i = 0; i < MAX_CHANNELS; i++) begin
          mod_r[i] <= '0;
        end
      end else begin
        pos_r <= pos_inc[POS_W-1:0];
        for (int i = 0; i < MAX_CHANNELS; i++) begin
          mod_r[i] <= (mod_r[i] == CH_W'(i)) ? '0 : mod_r[i] + CH_W'(1);
        end
      end
    end
  end

  // Input register: the sample and everything decoded about it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (data_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (data_fire) begin
      s1_x_r           <= in_stream_byte;
      s1_addr_r        <= pos_r[AW-1:0];
      s1_in_store_r    <= acc_in_store;
      s1_ch_r          <= acc_ch;
      s1_first_pixel_r <= acc_first_pixel;
      s1_first_row_r   <= row_idx_r == '0;
      s1_bad_r         <= acc_bad;
      s1_filt_r        <= filt_r[2:0];
      s1_row_end_r     <= acc_row_end;
      s1_image_end_r   <= acc_row_end && acc_image_end;
    end
  end

  // ---------------------------------------------------------------------------
  // Reconstruction of the sample held in the input register.
  logic [7:0] up_raw;
  logic [7:0] nb_a;
  logic [7:0] nb_b;
  logic [7:0] nb_c;
  logic [8:0] ab_sum;
  logic [7:0] pred;
  logic [7:0] result;

  always_comb begin
    up_raw = byp_r ? byp_data_r : rd_raw_r;
    nb_a   = s1_first_pixel_r ? 8'd0 : left_r[s1_ch_r];
    nb_b   = s1_first_row_r ? 8'd0 : up_raw;
    nb_c   = (s1_first_pixel_r || s1_first_row_r) ? 8'd0 : upleft_r[s1_ch_r];
    ab_sum = {1'b0, nb_a} + {1'b0, nb_b};
    case (filt_t'(s1_filt_r))
      FILT_SUB:     pred = nb_a;
      FILT_UP:      pred = nb_b;
      FILT_AVERAGE: pred = ab_sum[8:1];
      FILT_PAETH:   pred = paeth_pred(nb_a, nb_b, nb_c);
      default:      pred = 8'd0;
    endcase
    result = s1_bad_r ? 8'd0 : s1_x_r + pred;
  end

  // Line store write and registered read. A read of the entry being written in the
  // same cycle gets the written value forwarded.
  always_ff @(posedge clk) begin
    if (s1_fire && s1_in_store_r) begin
      line_mem[s1_addr_r] <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (data_fire) begin
      rd_raw_r <= line_mem[pos_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else if (data_fire) begin
      byp_r <= s1_fire && s1_in_store_r && (s1_addr_r == pos_r[AW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (data_fire) begin
      byp_data_r <= result;
    end
  end

  // Neighbor registers take the finished sample and the prior-row byte it used.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        left_r[i]   <= 8'd0;
        upleft_r[i] <= 8'd0;
      end
    end else if (s1_fire) begin
      left_r[s1_ch_r] <= result;
      if (s1_in_store_r) begin
        upleft_r[s1_ch_r] <= s1_first_row_r ? 8'd0 : up_raw;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_pixel_r     <= result;
      out_row_end_r   <= s1_row_end_r;
      out_image_end_r <= s1_image_end_r;
      out_bad_r       <= s1_bad_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_byte = out_pixel_r;
  assign out_row_end    = out_row_end_r;
  assign out_image_end  = out_image_end_r;
  assign out_bad_filter = out_bad_r;

endmodule

// ===== rtl/psu_checker.sv =====
// Port-level checker for the PNG scanline unfilter, bound to the top level.
// Depends on png_scanline_unfilter_assert.svh.
`include "png_scanline_unfilter_assert.svh"

module psu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_stream_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_pixel_byte,
  input logic        out_row_end,
  input logic        out_image_end,
  input logic        out_bad_filter
);

  // The last byte of the image is always also the last byte of its row.
  `PSU_ASSERT_IMPLY(a_image_end_row_end, out_valid && out_image_end, out_row_end)

  // A byte flagged bad is always reconstructed as zero.
  `PSU_ASSERT_IMPLY(a_bad_is_zero, out_valid && out_bad_filter, out_pixel_byte == 8'd0)

  // A stalled transaction keeps its payload.
  `PSU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_pixel_byte) && $stable(out_row_end)
                   && $stable(out_image_end) && $stable(out_bad_filter))

  // Coming out of reset the pipeline is empty and the input side is open.
  `PSU_ASSERT_NEXT_RST(a_reset_empty, !rst_n, !out_valid && in_ready)

endmodule

bind png_scanline_unfilter psu_checker u_psu_checker (.*);

// ===== bench/psu_pixel_checker.sv =====
// Scoreboard for the PNG scanline unfilter: watches the stream, result and register ports,
// rebuilds every sample byte on its own and compares the results. Depends on psu_pkg.
module psu_pixel_checker
  import psu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_stream_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_pixel_byte,
  input  logic        out_row_end,
  input  logic        out_image_end,
  input  logic        out_bad_filter,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatch_count,
  output int          results_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] pixel;
    logic       row_end;
    logic       image_end;
    logic       bad;
  } pixel_result_t;

  // Register copies, written from the observed register transactions.
  logic [WIDTH_W-1:0]  row_w;
  logic [CHAN_W-1:0]   chan_cnt;
  logic [HEIGHT_W-1:0] img_h;

  // Unfilter state: line store, neighbor samples and row/byte counters.
  logic [7:0]  line_mem [DEF_MAX_ROW_BYTES];
  logic [7:0]  left_px [DEF_MAX_CHANNELS];
  logic [7:0]  up_left_px [DEF_MAX_CHANNELS];
  int          byte_pos;
  logic [15:0] row_num;
  logic [7:0]  row_filter;
  logic        want_filter;

  pixel_result_t expected_pixels[$];
  int n_errors = 0;

  assign mismatch_count = n_errors;

  initial results_outstanding = 0;

  // Paeth predictor as written in the PNG specification.
  function automatic int paeth_pick(int a, int b, int c);
    int p;
    int pa;
    int pb;
    int pc;
    p  = a + b - c;
    pa = (p > a) ? p - a : a - p;
    pb = (p > b) ? p - b : b - p;
    pc = (p > c) ? p - c : c - p;
    if (pa <= pb && pa <= pc) begin
      return a;
    end
    if (pb <= pc) begin
      return b;
    end
    return c;
  endfunction

  // Rebuild one stream byte; a filter byte only opens the row.
  task automatic unfilter_byte(input logic [7:0] x);
    int chans;
    int width;
    int height;
    int row_bytes;
    int ch;
    int a;
    int b;
    int c;
    int pred;
    bit first_pix;
    bit first_row;
    pixel_result_t r;
    if (want_filter) begin
      row_filter  = x;
      want_filter = 1'b0;
      byte_pos    = 0;
      return;
    end
    chans = (chan_cnt == 0) ? 1 : int'(chan_cnt);
    if (chans > DEF_MAX_CHANNELS) begin
      chans = DEF_MAX_CHANNELS;
    end
    width     = (row_w == 0) ? 1 : int'(row_w);
    height    = (img_h == 0) ? 1 : int'(img_h);
    row_bytes = width * chans;
    ch        = byte_pos % chans;
    first_pix = byte_pos < chans;
    first_row = row_num == 0;
    a = 0;
    b = 0;
    c = 0;
    r = '0;
    if (byte_pos >= DEF_MAX_ROW_BYTES || row_filter > FILT_LAST) begin
      // Invalid filter type or a byte past the line store: zero with the error flag.
      r.bad = 1'b1;
    end else begin
      if (!first_pix) begin
        a = left_px[ch];
      end
      if (!first_row) begin
        b = line_mem[byte_pos];
      end
      if (!first_pix && !first_row) begin
        c = up_left_px[ch];
      end
      case (row_filter)
        FILT_SUB:     pred = a;
        FILT_UP:      pred = b;
        FILT_AVERAGE: pred = (a + b) / 2;
        FILT_PAETH:   pred = paeth_pick(a, b, c);
        default:      pred = 0;
      endcase
      r.pixel = 8'(int'(x) + pred);
    end
    if (byte_pos < DEF_MAX_ROW_BYTES) begin
      up_left_px[ch]     = first_row ? 8'd0 : line_mem[byte_pos];
      line_mem[byte_pos] = r.pixel;
    end
    left_px[ch] = r.pixel;
    r.row_end   = (byte_pos + 1) >= row_bytes;
    r.image_end = r.row_end && (int'(row_num) + 1 >= height);
    if (r.row_end) begin
      want_filter = 1'b1;
      byte_pos    = 0;
      row_num     = r.image_end ? 16'd0 : row_num + 16'd1;
    end else begin
      byte_pos = byte_pos + 1;
    end
    expected_pixels.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      n_errors++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endtask

  // Track registers and inputs, then score every result transaction in order.
  always @(posedge clk) begin
    pixel_result_t e;
    if (!rst_n) begin
      row_w       <= WIDTH_W'(1);
      chan_cnt    <= CHAN_W'(3);
      img_h       <= HEIGHT_W'(1);
      byte_pos    = 0;
      row_num     = '0;
      row_filter  = '0;
      want_filter = 1'b1;
      for (int i = 0; i < DEF_MAX_CHANNELS; i++) begin
        left_px[i]    = '0;
        up_left_px[i] = '0;
      end
      expected_pixels.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_ROW_WIDTH:     row_w    <= pwdata[WIDTH_W-1:0];
          REG_CHANNEL_COUNT: chan_cnt <= pwdata[CHAN_W-1:0];
          REG_IMAGE_HEIGHT:  img_h    <= pwdata[HEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        unfilter_byte(in_stream_byte);
      end
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          n_errors++;
          $display("%0t ns: result with none expected, expected nothing, got pixel %0h",
                   $time, out_pixel_byte);
        end else begin
          e = expected_pixels.pop_front();
          check_field("pixel_byte", e.pixel, out_pixel_byte);
          check_field("row_end", 8'(e.row_end), 8'(out_row_end));
          check_field("image_end", 8'(e.image_end), 8'(out_image_end));
          check_field("bad_filter", 8'(e.bad), 8'(out_bad_filter));
        end
      end
    end
    results_outstanding <= expected_pixels.size();
  end

endmodule

// ===== bench/tb_png_scanline_unfilter.sv =====
// Top of the scanline unfilter testbench: clock, reset, stream and register stimulus.
// Depends on psu_pkg, png_scanline_unfilter and psu_pixel_checker.
module tb_png_scanline_unfilter
  import psu_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASE_BYTES = 317;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_stream_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_pixel_byte;
  logic        out_row_end;
  logic        out_image_end;
  logic        out_bad_filter;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int in_flight;

  // Idle chances in percent for the stream sender and the result receiver.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Stimulus bookkeeping: register values and position in the image being sent.
  logic [WIDTH_W-1:0]  cfg_w = WIDTH_W'(1);
  logic [CHAN_W-1:0]   cfg_c = CHAN_W'(3);
  logic [HEIGHT_W-1:0] cfg_h = HEIGHT_W'(1);
  bit t_await = 1'b1;
  int t_pos = 0;
  int t_row = 0;
  int n_bytes = 0;
  int n_pixels = 0;
  int n_images = 0;
  int n_bad_rows = 0;

  png_scanline_unfilter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_stream_byte(in_stream_byte),
    .out_valid(out_valid), .out_ready(out_ready), .out_pixel_byte(out_pixel_byte),
    .out_row_end(out_row_end), .out_image_end(out_image_end),
    .out_bad_filter(out_bad_filter),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  psu_pixel_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_stream_byte(in_stream_byte),
    .out_valid(out_valid), .out_ready(out_ready), .out_pixel_byte(out_pixel_byte),
    .out_row_end(out_row_end), .out_image_end(out_image_end),
    .out_bad_filter(out_bad_filter),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready),
    .mismatch_count(mismatches), .results_outstanding(in_flight)
  );

  always #2 clk = ~clk;

  // Result side backpressure.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int eff_row_bytes();
    int w;
    int c;
    w = (cfg_w == 0) ? 1 : int'(cfg_w);
    c = (cfg_c == 0) ? 1 : int'(cfg_c);
    if (c > DEF_MAX_CHANNELS) begin
      c = DEF_MAX_CHANNELS;
    end
    return w * c;
  endfunction

  // One stream transaction; valid holds until accepted.
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) begin
        @(posedge clk);
      end
    end
    in_valid       <= 1'b1;
    in_stream_byte <= b;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
  endtask

  // Send a byte and advance the stimulus position the way the block counts.
  task automatic push_byte(input logic [7:0] b);
    send_byte(b);
    n_bytes++;
    if (t_await) begin
      t_await = 1'b0;
      t_pos   = 0;
      if (b > FILT_LAST) begin
        n_bad_rows++;
      end
    end else begin
      n_pixels++;
      if (t_pos + 1 >= eff_row_bytes()) begin
        t_await = 1'b1;
        t_pos   = 0;
        if (t_row + 1 >= ((cfg_h == 0) ? 1 : int'(cfg_h))) begin
          t_row = 0;
          n_images++;
        end else begin
          t_row++;
        end
      end else begin
        t_pos++;
      end
    end
  endtask

  // Let every pending result and the pipeline empty out.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic set_cfg(input reg_idx_t idx, input logic [31:0] val);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ROW_WIDTH:     cfg_w = val[WIDTH_W-1:0];
      REG_CHANNEL_COUNT: cfg_c = val[CHAN_W-1:0];
      REG_IMAGE_HEIGHT:  cfg_h = val[HEIGHT_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [7:0] sample_byte(input bit patterned);
    logic [7:0] pat [3];
    pat = '{8'h00, 8'hFF, 8'h80};
    if (patterned) begin
      return pat[(t_row + t_pos) % 3];
    end
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // One row with a given filter type.
  task automatic send_row(input logic [7:0] filt, input bit patterned);
    push_byte(filt);
    while (!t_await) begin
      push_byte(sample_byte(patterned));
    end
  endtask

  // A whole image with random filters; may shrink the geometry on the way.
  task automatic send_image(input bit allow_break);
    bit broke;
    broke = 1'b0;
    do begin
      if (t_await) begin
        push_byte(($urandom_range(9) == 0) ? 8'($urandom_range(5, 255))
                                           : 8'($urandom_range(0, 4)));
      end else begin
        if (allow_break && !broke && $urandom_range(199) == 0) begin
          // Shrinking the row or changing the height is safe mid-image.
          broke = 1'b1;
          if ($urandom_range(1) == 1) begin
            set_cfg(REG_ROW_WIDTH, $urandom_range(1, (cfg_w == 0) ? 1 : int'(cfg_w)));
          end else begin
            set_cfg(REG_IMAGE_HEIGHT, $urandom_range(0, 3));
          end
        end
        push_byte(sample_byte(1'b0));
      end
    end while (!(t_await && t_row == 0));
  endtask

  initial begin
    int start_bytes;
    int r;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 23 : (p == 1) ? 47 : 0;
      recv_idle_pct = (p == 0) ? 47 : (p == 1) ? 23 : 0;

      if (p == 0) begin
        // Every filter type over extreme sample values.
        set_cfg(REG_ROW_WIDTH, 1);
        set_cfg(REG_CHANNEL_COUNT, 2);
        set_cfg(REG_IMAGE_HEIGHT, 5);
        send_row(FILT_NONE, 1'b1);
        send_row(FILT_SUB, 1'b1);
        send_row(FILT_UP, 1'b1);
        send_row(FILT_AVERAGE, 1'b1);
        send_row(FILT_PAETH, 1'b1);
        // Filter types above the last valid one.
        set_cfg(REG_CHANNEL_COUNT, 1);
        set_cfg(REG_IMAGE_HEIGHT, 2);
        send_row(8'd5, 1'b1);
        send_row(8'hFF, 1'b1);
        // Zero registers act as one.
        set_cfg(REG_ROW_WIDTH, 0);
        set_cfg(REG_CHANNEL_COUNT, 0);
        set_cfg(REG_IMAGE_HEIGHT, 0);
        send_row(FILT_SUB, 1'b1);
        // Too many channels act as the maximum.
        set_cfg(REG_ROW_WIDTH, 1);
        set_cfg(REG_CHANNEL_COUNT, 7);
        set_cfg(REG_IMAGE_HEIGHT, 1);
        send_row(FILT_PAETH, 1'b1);
        // Tallest image, cut short by changes in the middle of a row.
        set_cfg(REG_ROW_WIDTH, 3);
        set_cfg(REG_CHANNEL_COUNT, 1);
        set_cfg(REG_IMAGE_HEIGHT, 16'hFFFF);
        send_row(FILT_NONE, 1'b1);
        push_byte(FILT_UP);
        push_byte(sample_byte(1'b1));
        push_byte(sample_byte(1'b1));
        set_cfg(REG_ROW_WIDTH, 1);
        push_byte(sample_byte(1'b1));
        set_cfg(REG_IMAGE_HEIGHT, 1);
        send_row(FILT_SUB, 1'b1);
      end

      // Random images with random geometry, changed between images and at most once inside each.
      start_bytes = n_bytes;
      while (n_bytes - start_bytes < PHASE_BYTES) begin
        if ($urandom_range(1) == 1) begin
          r = $urandom_range(19);
          set_cfg(REG_ROW_WIDTH, (r == 0) ? 0 : (r == 1) ? $urandom_range(7, 24)
                                                         : $urandom_range(1, 6));
          set_cfg(REG_CHANNEL_COUNT, ($urandom_range(3) == 0) ? $urandom_range(0, 7)
                                                              : $urandom_range(1, 4));
          set_cfg(REG_IMAGE_HEIGHT, ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4));
        end
        send_image(1'b1);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d stream bytes in %0d images, %0d rows with invalid filters;",
             n_bytes, n_images, n_bad_rows);
    $display("checked %0d rebuilt bytes under three backpressure mixes.", n_pixels);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
